// ===== hw/rtl/ecpm_pkg.sv =====
`timescale 1ns / 1ps

package ecpm_pkg;

  // Width of one field element and of the configuration registers.
  localparam int FIELD_BITS = 16;
  localparam int CNT_W      = $clog2(FIELD_BITS + 1);
  localparam int MULT_W     = 7;
  localparam int PC_W       = 5;

  // Largest multiple that one run emits, and the smallest.
  localparam logic [MULT_W-1:0] MAX_MULTIPLE = 7'd65;
  localparam logic [MULT_W-1:0] MIN_MULTIPLE = 7'd2;

  // Configuration register indexes.
  localparam logic [7:0] REG_MODULUS = 8'd0;
  localparam logic [7:0] REG_CURVE_A = 8'd1;

  // Datapath operations.
  typedef enum logic [2:0] {
    OP_MOD,
    OP_MUL,
    OP_ADD,
    OP_SUB,
    OP_INV
  } op_e;

  // Operand sources and destinations of the datapath.
  typedef enum logic [3:0] {
    SEL_ZERO,
    SEL_RAWX,
    SEL_RAWY,
    SEL_RAWA,
    SEL_A,
    SEL_X1,
    SEL_Y1,
    SEL_X2,
    SEL_Y2,
    SEL_N,
    SEL_D,
    SEL_S,
    SEL_T
  } sel_e;

  typedef struct packed {
    op_e  op;
    sel_e dst;
    sel_e srca;
    sel_e srcb;
  } uop_t;

  typedef struct packed {
    logic load;
    logic go;
    uop_t uop;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic busy;
    logic none;
  } dp_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_EMIT
  } ctl_state_e;

  // Microprogram landmarks.
  localparam logic [PC_W-1:0] PC_DBL_END = 5'd16;
  localparam logic [PC_W-1:0] PC_ADD     = 5'd17;
  localparam logic [PC_W-1:0] PC_ADD_END = 5'd27;

  // Microprogram: reduction of the inputs, point doubling, then point addition.
  function automatic uop_t uop_at(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      5'd0:  u = '{OP_MOD, SEL_A,  SEL_RAWA, SEL_ZERO};
      5'd1:  u = '{OP_MOD, SEL_X1, SEL_RAWX, SEL_ZERO};
      5'd2:  u = '{OP_MOD, SEL_Y1, SEL_RAWY, SEL_ZERO};
      5'd3:  u = '{OP_MUL, SEL_T,  SEL_X1,   SEL_X1};
      5'd4:  u = '{OP_ADD, SEL_N,  SEL_T,    SEL_T};
      5'd5:  u = '{OP_ADD, SEL_N,  SEL_N,    SEL_T};
      5'd6:  u = '{OP_ADD, SEL_N,  SEL_N,    SEL_A};
      5'd7:  u = '{OP_ADD, SEL_D,  SEL_Y1,   SEL_Y1};
      5'd8:  u = '{OP_INV, SEL_D,  SEL_D,    SEL_ZERO};
      5'd9:  u = '{OP_MUL, SEL_S,  SEL_N,    SEL_D};
      5'd10: u = '{OP_MUL, SEL_T,  SEL_S,    SEL_S};
      5'd11: u = '{OP_SUB, SEL_T,  SEL_T,    SEL_X1};
      5'd12: u = '{OP_SUB, SEL_T,  SEL_T,    SEL_X1};
      5'd13: u = '{OP_SUB, SEL_N,  SEL_X1,   SEL_T};
      5'd14: u = '{OP_MUL, SEL_N,  SEL_S,    SEL_N};
      5'd15: u = '{OP_SUB, SEL_Y2, SEL_N,    SEL_Y1};
      5'd16: u = '{OP_ADD, SEL_X2, SEL_T,    SEL_ZERO};
      5'd17: u = '{OP_SUB, SEL_N,  SEL_Y2,   SEL_Y1};
      5'd18: u = '{OP_SUB, SEL_D,  SEL_X2,   SEL_X1};
      5'd19: u = '{OP_INV, SEL_D,  SEL_D,    SEL_ZERO};
      5'd20: u = '{OP_MUL, SEL_S,  SEL_N,    SEL_D};
      5'd21: u = '{OP_MUL, SEL_T,  SEL_S,    SEL_S};
      5'd22: u = '{OP_SUB, SEL_T,  SEL_T,    SEL_X1};
      5'd23: u = '{OP_SUB, SEL_T,  SEL_T,    SEL_X2};
      5'd24: u = '{OP_SUB, SEL_N,  SEL_X1,   SEL_T};
      5'd25: u = '{OP_MUL, SEL_N,  SEL_S,    SEL_N};
      5'd26: u = '{OP_SUB, SEL_Y2, SEL_N,    SEL_Y1};
      5'd27: u = '{OP_ADD, SEL_X2, SEL_T,    SEL_ZERO};
      default: u = '{OP_ADD, SEL_T, SEL_T,   SEL_ZERO};
    endcase
    return u;
  endfunction

endpackage

// ===== hw/rtl/ecpm_dpath.sv =====
`timescale 1ns / 1ps

module ecpm_dpath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ecpm_pkg::dp_cmd_t                cmd_i,
  input  logic [ecpm_pkg::FIELD_BITS-1:0]  modulus_i,
  input  logic [ecpm_pkg::FIELD_BITS-1:0]  curve_a_i,
  input  logic [ecpm_pkg::FIELD_BITS-1:0]  base_x_i,
  input  logic [ecpm_pkg::FIELD_BITS-1:0]  base_y_i,
  output ecpm_pkg::dp_stat_t               stat_o,
  output logic [ecpm_pkg::FIELD_BITS-1:0]  point_x_o,
  output logic [ecpm_pkg::FIELD_BITS-1:0]  point_y_o
);

  localparam int W = ecpm_pkg::FIELD_BITS;
  localparam int C = ecpm_pkg::CNT_W;

  // Double p, then add b when bit is set, all modulo m (p and b below m).
  function automatic logic [W-1:0] dbl_add(input logic [W-1:0] p, input logic bit_i,
                                           input logic [W-1:0] b, input logic [W-1:0] m);
    logic [W:0] v;
    v = {p, 1'b0};
    if (v >= {1'b0, m}) v = v - {1'b0, m};
    if (bit_i) v = v + {1'b0, b};
    if (v >= {1'b0, m}) v = v - {1'b0, m};
    return v[W-1:0];
  endfunction

  // Modular subtraction of reduced operands.
  function automatic logic [W-1:0] sub_mod(input logic [W-1:0] a, input logic [W-1:0] b,
                                           input logic [W-1:0] m);
    logic [W:0] v;
    if (a >= b) v = {1'b0, a} - {1'b0, b};
    else v = {1'b0, a} + {1'b0, m} - {1'b0, b};
    return v[W-1:0];
  endfunction

  // Element registers.
  logic [W-1:0] z_q, rawx_q, rawy_q, rawa_q;
  logic [W-1:0] a_q, x1_q, y1_q, x2_q, y2_q, n_q, d_q, s_q, t_q;

  // Serial unit state.
  logic              busy_q, done_q, none_q, div_q;
  ecpm_pkg::op_e     op_q;
  ecpm_pkg::sel_e    dst_q;
  logic [C-1:0]      cnt_q;
  logic [W-1:0]      sh_q, b_q, acc_q;
  logic [W-1:0]      r0_q, r1_q, t0_q, t1_q, p_q;

  logic [W-1:0]      opa, opb, add_res, sub_res;
  logic [W:0]        rem2, divisor, sum;
  logic              qbit, last_bit, inv_ok, inv_fin;
  logic [W-1:0]      rem_nx, mul_nx, p_nx;
  logic              wr_en;
  ecpm_pkg::sel_e    wr_sel;
  logic [W-1:0]      wr_val;

  // Operand selection.
  function automatic logic [W-1:0] pick(input ecpm_pkg::sel_e s,
      input logic [W-1:0] rx, input logic [W-1:0] ry, input logic [W-1:0] ra,
      input logic [W-1:0] va, input logic [W-1:0] vx1, input logic [W-1:0] vy1,
      input logic [W-1:0] vx2, input logic [W-1:0] vy2, input logic [W-1:0] vn,
      input logic [W-1:0] vd, input logic [W-1:0] vs, input logic [W-1:0] vt);
    logic [W-1:0] r;
    case (s)
      ecpm_pkg::SEL_RAWX: r = rx;
      ecpm_pkg::SEL_RAWY: r = ry;
      ecpm_pkg::SEL_RAWA: r = ra;
      ecpm_pkg::SEL_A:    r = va;
      ecpm_pkg::SEL_X1:   r = vx1;
      ecpm_pkg::SEL_Y1:   r = vy1;
      ecpm_pkg::SEL_X2:   r = vx2;
      ecpm_pkg::SEL_Y2:   r = vy2;
      ecpm_pkg::SEL_N:    r = vn;
      ecpm_pkg::SEL_D:    r = vd;
      ecpm_pkg::SEL_S:    r = vs;
      ecpm_pkg::SEL_T:    r = vt;
      default:            r = '0;
    endcase
    return r;
  endfunction

  assign opa = pick(cmd_i.uop.srca, rawx_q, rawy_q, rawa_q, a_q, x1_q, y1_q,
                    x2_q, y2_q, n_q, d_q, s_q, t_q);
  assign opb = pick(cmd_i.uop.srcb, rawx_q, rawy_q, rawa_q, a_q, x1_q, y1_q,
                    x2_q, y2_q, n_q, d_q, s_q, t_q);

  // Combinational modular add and subtract.
  assign sum     = {1'b0, opa} + {1'b0, opb};
  assign add_res = (sum >= {1'b0, z_q}) ? W'(sum - {1'b0, z_q}) : sum[W-1:0];
  assign sub_res = sub_mod(opa, opb, z_q);

  // One restoring-division step; its quotient bit also drives the Euclid product.
  assign divisor  = (op_q == ecpm_pkg::OP_INV) ? {1'b0, r1_q} : {1'b0, z_q};
  assign rem2     = {acc_q, sh_q[W-1]};
  assign qbit     = rem2 >= divisor;
  assign rem_nx   = qbit ? W'(rem2 - divisor) : rem2[W-1:0];
  assign mul_nx   = dbl_add(acc_q, sh_q[W-1], b_q, z_q);
  assign p_nx     = dbl_add(p_q, qbit, t1_q, z_q);
  assign last_bit = cnt_q == C'(1);
  assign inv_ok   = (z_q >= W'(2)) && (r0_q == W'(1));
  assign inv_fin  = (z_q < W'(2)) || (r1_q == '0);

  // Write-back of finished results.
  always_comb begin
    wr_en  = 1'b0;
    wr_sel = cmd_i.go ? cmd_i.uop.dst : dst_q;
    wr_val = '0;
    if (cmd_i.go) begin
      if (cmd_i.uop.op == ecpm_pkg::OP_ADD) begin
        wr_en  = 1'b1;
        wr_val = add_res;
      end else if (cmd_i.uop.op == ecpm_pkg::OP_SUB) begin
        wr_en  = 1'b1;
        wr_val = sub_res;
      end
    end else if (busy_q) begin
      case (op_q)
        ecpm_pkg::OP_MOD: begin
          wr_en  = last_bit;
          wr_val = rem_nx;
        end
        ecpm_pkg::OP_MUL: begin
          wr_en  = last_bit;
          wr_val = mul_nx;
        end
        ecpm_pkg::OP_INV: begin
          wr_en  = !div_q && inv_fin;
          wr_val = inv_ok ? t0_q : '0;
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  // Element register file.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      z_q    <= (modulus_i == '0) ? W'(1) : modulus_i;
      rawx_q <= base_x_i;
      rawy_q <= base_y_i;
      rawa_q <= curve_a_i;
    end
    if (wr_en) begin
      case (wr_sel)
        ecpm_pkg::SEL_A:  a_q  <= wr_val;
        ecpm_pkg::SEL_X1: x1_q <= wr_val;
        ecpm_pkg::SEL_Y1: y1_q <= wr_val;
        ecpm_pkg::SEL_X2: x2_q <= wr_val;
        ecpm_pkg::SEL_Y2: y2_q <= wr_val;
        ecpm_pkg::SEL_N:  n_q  <= wr_val;
        ecpm_pkg::SEL_D:  d_q  <= wr_val;
        ecpm_pkg::SEL_S:  s_q  <= wr_val;
        ecpm_pkg::SEL_T:  t_q  <= wr_val;
        default: ;
      endcase
    end
  end

  // Serial unit sequencing: reduction, multiplication and inversion.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      none_q <= 1'b0;
      div_q  <= 1'b0;
      op_q   <= ecpm_pkg::OP_ADD;
      dst_q  <= ecpm_pkg::SEL_ZERO;
      cnt_q  <= '0;
      sh_q   <= '0;
      b_q    <= '0;
      acc_q  <= '0;
      r0_q   <= '0;
      r1_q   <= '0;
      t0_q   <= '0;
      t1_q   <= '0;
      p_q    <= '0;
    end else begin
      done_q <= wr_en;
      if (cmd_i.go) begin
        op_q  <= cmd_i.uop.op;
        dst_q <= cmd_i.uop.dst;
        sh_q  <= opa;
        b_q   <= opb;
        acc_q <= '0;
        cnt_q <= C'(W);
        div_q <= 1'b0;
        r0_q  <= z_q;
        r1_q  <= opa;
        t0_q  <= '0;
        t1_q  <= W'(1);
        busy_q <= (cmd_i.uop.op == ecpm_pkg::OP_MOD) || (cmd_i.uop.op == ecpm_pkg::OP_MUL) ||
                  (cmd_i.uop.op == ecpm_pkg::OP_INV);
      end else if (busy_q) begin
        case (op_q)
          ecpm_pkg::OP_MOD: begin
            sh_q  <= {sh_q[W-2:0], 1'b0};
            acc_q <= rem_nx;
            cnt_q <= cnt_q - C'(1);
            if (last_bit) busy_q <= 1'b0;
          end
          ecpm_pkg::OP_MUL: begin
            sh_q  <= {sh_q[W-2:0], 1'b0};
            acc_q <= mul_nx;
            cnt_q <= cnt_q - C'(1);
            if (last_bit) busy_q <= 1'b0;
          end
          ecpm_pkg::OP_INV: begin
            if (!div_q) begin
              // Check for the end of Euclid, otherwise start the next quotient.
              if (inv_fin) begin
                busy_q <= 1'b0;
                none_q <= !inv_ok;
              end else begin
                div_q <= 1'b1;
                sh_q  <= r0_q;
                acc_q <= '0;
                p_q   <= '0;
                cnt_q <= C'(W);
              end
            end else begin
              sh_q  <= {sh_q[W-2:0], 1'b0};
              acc_q <= rem_nx;
              p_q   <= p_nx;
              cnt_q <= cnt_q - C'(1);
              if (last_bit) begin
                // Quotient complete: shift the remainder and cofactor pairs.
                r0_q  <= r1_q;
                r1_q  <= rem_nx;
                t0_q  <= t1_q;
                t1_q  <= sub_mod(t0_q, p_nx, z_q);
                div_q <= 1'b0;
              end
            end
          end
          default: busy_q <= 1'b0;
        endcase
      end
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.busy = busy_q;
  assign stat_o.none = none_q;
  assign point_x_o   = x2_q;
  assign point_y_o   = y2_q;

endmodule

// ===== hw/rtl/ecpm_ctrl.sv =====
`timescale 1ns / 1ps

module ecpm_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ecpm_pkg::MULT_W-1:0]    scalar_i,
  input  logic                           out_free_i,
  output logic                           emit_o,
  output logic [ecpm_pkg::MULT_W-1:0]    multiple_o,
  output logic                           last_o,
  output ecpm_pkg::dp_cmd_t              cmd_o,
  input  ecpm_pkg::dp_stat_t             stat_i
);

  ecpm_pkg::ctl_state_e state_q, state_d;
  logic [ecpm_pkg::PC_W-1:0]   pc_q, pc_d;
  logic [ecpm_pkg::MULT_W-1:0] k_q, k_d, mult_q, mult_d, k_sat;

  // Scalar clamped to the supported range of multiples.
  assign k_sat = (scalar_i < ecpm_pkg::MIN_MULTIPLE) ? ecpm_pkg::MIN_MULTIPLE :
                 (scalar_i > ecpm_pkg::MAX_MULTIPLE) ? ecpm_pkg::MAX_MULTIPLE : scalar_i;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ecpm_pkg::ST_IDLE;
      pc_q    <= '0;
      k_q     <= ecpm_pkg::MIN_MULTIPLE;
      mult_q  <= ecpm_pkg::MIN_MULTIPLE;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      k_q     <= k_d;
      mult_q  <= mult_d;
    end
  end

  // Next state and commands to the datapath.
  always_comb begin
    state_d    = state_q;
    pc_d       = pc_q;
    k_d        = k_q;
    mult_d     = mult_q;
    in_ready_o = 1'b0;
    emit_o     = 1'b0;
    cmd_o.load = 1'b0;
    cmd_o.go   = 1'b0;
    cmd_o.uop  = ecpm_pkg::uop_at(pc_q);
    case (state_q)
      ecpm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          k_d        = k_sat;
          mult_d     = ecpm_pkg::MIN_MULTIPLE;
          pc_d       = '0;
          state_d    = ecpm_pkg::ST_ISSUE;
        end
      end
      ecpm_pkg::ST_ISSUE: begin
        cmd_o.go = 1'b1;
        state_d  = ecpm_pkg::ST_WAIT;
      end
      ecpm_pkg::ST_WAIT: begin
        if (stat_i.done) begin
          if (pc_q == ecpm_pkg::PC_DBL_END || pc_q == ecpm_pkg::PC_ADD_END) begin
            state_d = ecpm_pkg::ST_EMIT;
          end else begin
            pc_d    = pc_q + ecpm_pkg::PC_W'(1);
            state_d = ecpm_pkg::ST_ISSUE;
          end
        end
      end
      ecpm_pkg::ST_EMIT: begin
        if (out_free_i) begin
          emit_o = 1'b1;
          if (mult_q == k_q) begin
            state_d = ecpm_pkg::ST_IDLE;
          end else begin
            mult_d  = mult_q + ecpm_pkg::MULT_W'(1);
            pc_d    = ecpm_pkg::PC_ADD;
            state_d = ecpm_pkg::ST_ISSUE;
          end
        end
      end
      default: state_d = ecpm_pkg::ST_IDLE;
    endcase
  end

  assign multiple_o = mult_q;
  assign last_o     = mult_q == k_q;

endmodule

// ===== hw/rtl/ecc_point_multiples.sv =====
`timescale 1ns / 1ps

// Elliptic-curve point multiples over a prime field.
// Input channel (s_axis): one word carries a base point P and a scalar k. The block
// answers with the affine points 2P, 3P, ... kP on y^2 = x^3 + a*x + b modulo the
// configured modulus, one output word per multiple, tlast set on kP. tuser flags a
// step whose denominator had no inverse (zero then stands in for the inverse).
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_addr_i (0 modulus,
// 1 curve coefficient a) at the clock edge; write only while the block is idle.
// Timing: multiply, reduction and inverse run on one bit-serial unit that handles one bit a
// cycle, with a check step before each Euclid quotient; add and subtract are combinational.
// A multiply or reduction makes one pass over the 16 bits, and an inverse one restoring
// division per Euclid quotient (at most 23 quotients for 16 bits). The next input word
// is taken once the last result of the run has gone into the output register.
// Reset clears the control state and sets modulus 23 and coefficient 1.
// When the receiver stalls, the finished word waits in the output register and the
// sequencer holds until it has been taken.
module ecc_point_multiples (
  input  logic        clk_i,
  input  logic        rst_ni,
  // base_x[15:0], base_y[31:16], scalar[38:32], zero padding
  input  logic [39:0] s_axis_tdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // multiple[6:0], point_x[22:7], point_y[38:23], zero padding
  output logic [39:0] m_axis_tdata_o,
  // no_inverse[0]
  output logic        m_axis_tuser_o,
  output logic        m_axis_tlast_o,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int W = ecpm_pkg::FIELD_BITS;

  logic [W-1:0] modulus_q, curve_a_q;
  logic [W-1:0] px, py;
  logic         ctl_emit, ctl_last, out_free;
  logic [ecpm_pkg::MULT_W-1:0] ctl_mult;
  ecpm_pkg::dp_cmd_t  cmd;
  ecpm_pkg::dp_stat_t stat;

  logic                        out_valid_q, out_last_q, out_none_q;
  logic [ecpm_pkg::MULT_W-1:0] out_mult_q;
  logic [W-1:0]                out_x_q, out_y_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= W'(23);
      curve_a_q <= W'(1);
    end else if (cfg_we_i) begin
      if (cfg_addr_i == ecpm_pkg::REG_MODULUS) modulus_q <= cfg_wdata_i;
      else if (cfg_addr_i == ecpm_pkg::REG_CURVE_A) curve_a_q <= cfg_wdata_i;
    end
  end

  ecpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .scalar_i   (s_axis_tdata_i[38:32]),
    .out_free_i (out_free),
    .emit_o     (ctl_emit),
    .multiple_o (ctl_mult),
    .last_o     (ctl_last),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  ecpm_dpath u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .modulus_i (modulus_q),
    .curve_a_i (curve_a_q),
    .base_x_i  (s_axis_tdata_i[15:0]),
    .base_y_i  (s_axis_tdata_i[31:16]),
    .stat_o    (stat),
    .point_x_o (px),
    .point_y_o (py)
  );

  // Output register: free when empty or being taken this cycle.
  assign out_free = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_emit) begin
      out_mult_q <= ctl_mult;
      out_x_q    <= px;
      out_y_q    <= py;
      out_none_q <= stat.none;
      out_last_q <= ctl_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_y_q, out_x_q, out_mult_q};
  assign m_axis_tuser_o  = out_none_q;
  assign m_axis_tlast_o  = out_last_q;

`ifndef NO_ASSERTIONS
  // A new word is never loaded over one that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_emit |-> (!out_valid_q || m_axis_tready_i))
    else $error("result loaded over a pending word");

  // The sequencer only starts an operation on an idle serial unit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.go |-> !stat.busy)
    else $error("operation issued while the serial unit is busy");

  // Emitted multiples stay in the supported range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_emit |-> (ctl_mult >= ecpm_pkg::MIN_MULTIPLE && ctl_mult <= ecpm_pkg::MAX_MULTIPLE))
    else $error("multiple out of range");

  // Input is never taken while a run is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.busy || cmd.go) |-> !s_axis_tready_o)
    else $error("input ready during a run");
`endif

endmodule

// ===== tb/ecc_point_multiples_test.sv =====
`timescale 1ns / 1ps

module ecc_point_multiples_test;

  localparam logic [7:0] REG_UNUSED = 8'd2;
  localparam longint CYCLE_LIMIT = 16000000;
  localparam int DRAIN_CYCLES = 64;

  typedef struct {
    logic [6:0]  mult;
    logic [15:0] px;
    logic [15:0] py;
    logic        none;
    logic        last;
  } multiple_t;

  logic        clk_i;
  logic        rst_ni;
  logic [39:0] s_axis_tdata_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [39:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        m_axis_tlast_o;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic        cfg_we_i;
  logic [7:0]  cfg_addr_i;
  logic [15:0] cfg_wdata_i;

  logic [39:0] point_q[$];
  multiple_t   multiples_q[$];
  logic [15:0] modulus_cfg;
  logic [15:0] curve_a_cfg;
  int          words_in = 0;
  int          mismatches = 0;
  longint      cycles = 0;

  ecc_point_multiples dut (.*);

  // Clock and the single reset at the start.
  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    #(12 * 12) rst_ni = 1'b1;
  end

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Idle percentages follow the number of words sent so far.
  function automatic int sender_idle();
    if (words_in < 50) return 22;
    if (words_in < 100) return 46;
    return 0;
  endfunction

  function automatic int receiver_idle();
    if (words_in < 50) return 46;
    if (words_in < 100) return 22;
    return 0;
  endfunction

  // Extended Euclid; flags a missing inverse and returns zero then.
  function automatic longint unsigned mod_inverse(input longint unsigned v,
                                                  input longint unsigned m,
                                                  output logic none);
    longint r0, r1, t0, t1, q, tmp;
    if (m < 2) begin
      none = 1'b1;
      return 0;
    end
    r0 = m;
    r1 = v % m;
    t0 = 0;
    t1 = 1;
    while (r1 != 0) begin
      q = r0 / r1;
      tmp = r0 - q * r1; r0 = r1; r1 = tmp;
      tmp = t0 - q * t1; t0 = t1; t1 = tmp;
    end
    if (r0 != 1) begin
      none = 1'b1;
      return 0;
    end
    if (t0 < 0) t0 += m;
    none = 1'b0;
    return longint'(t0) % m;
  endfunction

  // Computes the multiples 2P..kP of one input word and queues them.
  task automatic predict_multiples(input logic [39:0] w);
    longint unsigned z, a, x1, y1, k, n, d, s, x3, y3, nx, inv;
    logic none;
    multiple_t r;
    z = (modulus_cfg == 0) ? 1 : modulus_cfg;
    a = curve_a_cfg % z;
    x1 = w[15:0] % z;
    y1 = w[31:16] % z;
    k = w[38:32];
    if (k < 2) k = 2;
    if (k > ecpm_pkg::MAX_MULTIPLE) k = ecpm_pkg::MAX_MULTIPLE;
    // Doubling step.
    n = ((3 % z) * (x1 * x1 % z) % z + a) % z;
    d = (2 % z) * y1 % z;
    inv = mod_inverse(d, z, none);
    s = n * inv % z;
    x3 = (s * s % z + z - (x1 + x1) % z) % z;
    y3 = (s * ((x1 + z - x3) % z) % z + z - y1) % z;
    for (longint unsigned i = 2; i <= k; i++) begin
      r.mult = i[6:0];
      r.px = x3[15:0];
      r.py = y3[15:0];
      r.none = none;
      r.last = (i == k);
      multiples_q.push_back(r);
      if (i >= k) break;
      // Adding P to the previous multiple.
      n = (y3 + z - y1) % z;
      d = (x3 + z - x1) % z;
      inv = mod_inverse(d, z, none);
      s = n * inv % z;
      nx = ((s * s % z + z - x1) % z + z - x3) % z;
      y3 = (s * ((x1 + z - nx) % z) % z + z - y1) % z;
      x3 = nx;
    end
  endtask

  // Driver: takes the next pending word when the slot is free.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i <= '0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_multiples(s_axis_tdata_i);
        words_in++;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (point_q.size() > 0 && $urandom_range(99) >= sender_idle()) begin
          s_axis_tdata_i <= point_q.pop_front();
          s_axis_tvalid_i <= 1'b1;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: stalls the output at random and checks each word taken.
  always @(posedge clk_i or negedge rst_ni) begin
    multiple_t e;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (multiples_q.size() == 0) begin
          if (mismatches < 10) $display("unexpected word %h", m_axis_tdata_o);
          mismatches++;
        end else begin
          e = multiples_q.pop_front();
          if (m_axis_tdata_o[6:0] !== e.mult || m_axis_tdata_o[22:7] !== e.px ||
              m_axis_tdata_o[38:23] !== e.py || m_axis_tdata_o[39] !== 1'b0 ||
              m_axis_tuser_o !== e.none || m_axis_tlast_o !== e.last) begin
            if (mismatches < 10)
              $display("mismatch: exp mult %0d x %0d y %0d none %b last %b, got %0d %0d %0d %b %b",
                       e.mult, e.px, e.py, e.none, e.last, m_axis_tdata_o[6:0],
                       m_axis_tdata_o[22:7], m_axis_tdata_o[38:23], m_axis_tuser_o,
                       m_axis_tlast_o);
            mismatches++;
          end
        end
      end
      m_axis_tready_i <= ($urandom_range(99) >= receiver_idle());
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL ecc_point_multiples");
      $finish;
    end
  end

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == ecpm_pkg::REG_MODULUS) modulus_cfg = value;
    else if (idx == ecpm_pkg::REG_CURVE_A) curve_a_cfg = value;
  endtask

  task automatic add_point(input logic [15:0] x, input logic [15:0] y,
                           input logic [6:0] k);
    point_q.push_back({1'b0, k, y, x});
  endtask

  // Mostly short runs; now and then a large scalar, most often one that saturates.
  task automatic add_random_points(input int count);
    logic [6:0] k;
    repeat (count) begin
      if ($urandom_range(99) < 4) k = 7'($urandom_range(64, 127));
      else k = 7'($urandom_range(0, 9));
      add_point(16'($urandom), 16'($urandom), k);
    end
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (point_q.size() != 0 || s_axis_tvalid_i || multiples_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    cfg_we_i = 1'b0;
    cfg_addr_i = '0;
    cfg_wdata_i = '0;
    modulus_cfg = 16'd23;
    curve_a_cfg = 16'd1;
    @(posedge rst_ni);
    repeat (3) @(posedge clk_i);

    // Directed words under the reset curve.
    add_point(16'd0, 16'd0, 7'd0);
    add_point(16'd3, 16'd10, 7'd1);
    add_point(16'd3, 16'd10, 7'd12);
    add_point(16'hFFFF, 16'hFFFF, 7'd127);
    add_point(16'd5, 16'd0, 7'd3);
    add_point(16'd9, 16'd16, 7'd65);
    add_point(16'd26, 16'd33, 7'd48);
    add_point(16'h8000, 16'h4000, 7'd2);
    add_random_points(14);
    drain();

    // Widest modulus and coefficient; an unmapped index is ignored.
    write_reg(ecpm_pkg::REG_MODULUS, 16'hFFFF);
    write_reg(ecpm_pkg::REG_CURVE_A, 16'hFFFF);
    write_reg(REG_UNUSED, 16'h1234);
    add_point(16'hFFFF, 16'h0000, 7'd4);
    add_random_points(20);
    drain();

    // A zero modulus behaves as modulus one.
    write_reg(ecpm_pkg::REG_MODULUS, 16'd0);
    write_reg(ecpm_pkg::REG_CURVE_A, 16'd0);
    add_random_points(8);
    drain();

    write_reg(ecpm_pkg::REG_MODULUS, 16'd1);
    add_random_points(8);
    drain();

    write_reg(ecpm_pkg::REG_MODULUS, 16'd2);
    write_reg(ecpm_pkg::REG_CURVE_A, 16'd1);
    add_random_points(10);
    drain();

    write_reg(ecpm_pkg::REG_MODULUS, 16'd97);
    write_reg(ecpm_pkg::REG_CURVE_A, 16'($urandom));
    add_random_points(25);
    drain();

    write_reg(ecpm_pkg::REG_MODULUS, 16'd65521);
    write_reg(ecpm_pkg::REG_CURVE_A, 16'($urandom));
    add_random_points(25);
    drain();

    write_reg(ecpm_pkg::REG_MODULUS, 16'($urandom_range(2, 65535)));
    write_reg(ecpm_pkg::REG_CURVE_A, 16'($urandom));
    add_random_points(25);
    drain();

    if (mismatches == 0) begin
      $display("PASS ecc_point_multiples");
    end else begin
      $display("FAIL ecc_point_multiples");
    end
    $finish;
  end

endmodule
